>>> rtl/dbot_pkg.sv
// ----------------------------------------------------------------------------
// dbot_pkg: shared types and codes for the depth bucket ordering table
// Opcodes, status codes, field widths and the controller/datapath words.
// ----------------------------------------------------------------------------
package dbot_pkg;

    // field widths fixed by the interface
    localparam int DEPTH_W = 9;
    localparam int ITEM_W  = 6;
    localparam int USED_W  = 7;

    // opcodes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_FLUSH  = 2'd1;
    localparam logic [1:0] OP_RESET  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_FLUSHED  = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_REJECTED = 2'd3;

    // bucket head memory address source
    typedef enum logic [1:0] {
        HA_DEPTH_IN,
        HA_DEPTH_REG,
        HA_SCAN
    } head_sel_t;

    // result word to launch
    typedef enum logic [2:0] {
        EM_NONE,
        EM_REJECT,
        EM_INSERT,
        EM_PEND_MID,
        EM_PEND_LAST,
        EM_EMPTY
    } emit_t;

    // controller to datapath commands
    typedef struct packed {
        head_sel_t head_sel;
        logic      head_we;
        logic      head_wd_item;
        logic      link_we;
        logic      cur_from_link;
        logic      ins_load;
        logic      alloc_reset;
        logic      scan_init;
        logic      scan_dec;
        logic      sweep_inc;
        logic      push;
        emit_t     emit;
    } dbot_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic reject;
        logic cur_nz;
        logic count_full;
        logic d_zero;
        logic d_top;
        logic pend_v;
    } dbot_stat_t;

endpackage

>>> rtl/depth_bucket_ordering_table.sv
// ----------------------------------------------------------------------------
// Insert: busy while the item is linked in (S_INS), so the next op waits;
// its word is registered out of S_INS. A reject answers next cycle and leaves
// busy low. Flush: busy while each bucket from the deepest mark down to 0 is
// fetched and cleared and its list walked item by item, then S_END closes it.
// Reset op: busy stays low, no word. The receiver cannot stall the results.
// After reset, busy stays high while the clear sweep zeroes every bucket head.
// ----------------------------------------------------------------------------
// depth_bucket_ordering_table: depth ordering table
// Bucket-sorted item lists by depth, drained deepest first on a flush.
// ----------------------------------------------------------------------------
module depth_bucket_ordering_table
    import dbot_pkg::*;
#(
    parameter int DEPTH_LEVELS  = 512,
    parameter int ITEM_CAPACITY = 63
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         opcode,
    input  logic [DEPTH_W-1:0] depth,
    output logic               strobe,
    output logic [ITEM_W-1:0]  item_number,
    output logic [1:0]         status,
    output logic               last
);

    dbot_cmd_t  cmd;
    dbot_stat_t stat;

    dbot_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy)
    );

    dbot_datapath #(
        .DEPTH_LEVELS  (DEPTH_LEVELS),
        .ITEM_CAPACITY (ITEM_CAPACITY)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .depth       (depth),
        .cmd         (cmd),
        .stat        (stat),
        .strobe      (strobe),
        .item_number (item_number),
        .status      (status),
        .last        (last)
    );

    // only flushed items may be non-final words
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> status == ST_FLUSHED)
        else $error("non-final word with wrong status");

    // empty flush and reject carry no item
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (status == ST_EMPTY || status == ST_REJECTED) |-> item_number == '0)
        else $error("item number on an empty or rejected word");

    // a granted item is never number zero
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (status == ST_INSERTED || status == ST_FLUSHED) |-> item_number != '0)
        else $error("zero item number emitted");

    // an accepted insert either answers at once or goes busy
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && opcode == OP_INSERT |=> strobe || busy)
        else $error("insert lost");

    // allocator reset gives no word
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && opcode == OP_RESET |=> !strobe && !busy)
        else $error("allocator reset produced a word");

endmodule

>>> rtl/dbot_datapath.sv
// ----------------------------------------------------------------------------
// dbot_datapath: storage and arithmetic of the ordering table
// Bucket head and link memories, allocator, scan pointer and result registers.
// ----------------------------------------------------------------------------
module dbot_datapath
    import dbot_pkg::*;
#(
    parameter int DEPTH_LEVELS  = 512,
    parameter int ITEM_CAPACITY = 63
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [DEPTH_W-1:0] depth,
    input  dbot_cmd_t          cmd,
    output dbot_stat_t         stat,
    output logic               strobe,
    output logic [ITEM_W-1:0]  item_number,
    output logic [1:0]         status,
    output logic               last
);

    localparam int AW = $clog2(DEPTH_LEVELS);

    logic [ITEM_W-1:0]  head_mem [DEPTH_LEVELS];
    logic [ITEM_W-1:0]  link_mem [2**ITEM_W];

    logic [ITEM_W-1:0]  head_rd_reg;
    logic [ITEM_W-1:0]  link_rd_reg;
    logic [AW-1:0]      head_addr;
    logic [ITEM_W-1:0]  head_wd;
    logic [ITEM_W-1:0]  cur;

    logic [31:0]        depth_ext;
    logic               depth_ok;
    logic [AW-1:0]      depth_idx;
    logic [AW-1:0]      scan_start;

    logic [AW-1:0]      depth_reg;
    logic [ITEM_W-1:0]  item_reg;
    logic [USED_W-1:0]  items_used_reg;
    logic [DEPTH_W-1:0] deepest_used_reg;
    logic [AW-1:0]      d_reg;
    logic [ITEM_W-1:0]  count_reg;
    logic               pend_v_reg;
    logic [ITEM_W-1:0]  pend_reg;

    logic               strobe_reg;
    logic [ITEM_W-1:0]  item_out_reg;
    logic [1:0]         status_reg;
    logic               last_reg;

    // depth range check and bucket index
    assign depth_ext = 32'(depth);
    assign depth_ok  = depth_ext < 32'(DEPTH_LEVELS);
    assign depth_idx = depth_ext[AW-1:0];

    // deepest mark clamped to the table
    always_comb
    begin
        if (32'(deepest_used_reg) >= 32'(DEPTH_LEVELS))
            scan_start = AW'(DEPTH_LEVELS - 1);
        else
            scan_start = AW'(deepest_used_reg);
    end

    // head memory address and write data
    always_comb
    begin
        case (cmd.head_sel)
            HA_DEPTH_IN:  head_addr = depth_idx;
            HA_DEPTH_REG: head_addr = depth_reg;
            HA_SCAN:      head_addr = d_reg;
            default:      head_addr = d_reg;
        endcase
    end

    assign head_wd = cmd.head_wd_item ? item_reg : '0;

    // current list entry under the walk
    assign cur = cmd.cur_from_link ? link_rd_reg : head_rd_reg;

    // bucket heads: read-first, one port
    always_ff @(posedge clk)
    begin
        head_rd_reg <= head_mem[head_addr];
        if (cmd.head_we)
            head_mem[head_addr] <= head_wd;
    end

    // item links: write at the new item, read at the walk position
    always_ff @(posedge clk)
    begin
        link_rd_reg <= link_mem[cur];
        if (cmd.link_we)
            link_mem[item_reg] <= head_rd_reg;
    end

    // insert payload
    always_ff @(posedge clk)
    begin
        if (cmd.ins_load)
        begin
            depth_reg <= depth_idx;
            item_reg  <= ITEM_W'(items_used_reg + USED_W'(1));
        end
        if (cmd.push)
            pend_reg <= cur;
    end

    // allocator, scan pointer and walk counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            items_used_reg   <= '0;
            deepest_used_reg <= '0;
            d_reg            <= '0;
            count_reg        <= '0;
            pend_v_reg       <= 1'b0;
        end
        else
        begin
            if (cmd.alloc_reset)
            begin
                items_used_reg   <= '0;
                deepest_used_reg <= '0;
            end
            else if (cmd.ins_load)
            begin
                items_used_reg <= items_used_reg + USED_W'(1);
                if (depth > deepest_used_reg)
                    deepest_used_reg <= depth;
            end

            if (cmd.scan_init)
                d_reg <= scan_start;
            else if (cmd.scan_dec)
                d_reg <= d_reg - AW'(1);
            else if (cmd.sweep_inc)
                d_reg <= d_reg + AW'(1);

            if (cmd.scan_init)
            begin
                count_reg  <= '0;
                pend_v_reg <= 1'b0;
            end
            else if (cmd.push)
            begin
                count_reg  <= count_reg + ITEM_W'(1);
                pend_v_reg <= 1'b1;
            end
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= (cmd.emit != EM_NONE);
    end

    // result word
    always_ff @(posedge clk)
    begin
        case (cmd.emit)
            EM_REJECT:
            begin
                item_out_reg <= '0;
                status_reg   <= ST_REJECTED;
                last_reg     <= 1'b1;
            end
            EM_INSERT:
            begin
                item_out_reg <= item_reg;
                status_reg   <= ST_INSERTED;
                last_reg     <= 1'b1;
            end
            EM_PEND_MID:
            begin
                item_out_reg <= pend_reg;
                status_reg   <= ST_FLUSHED;
                last_reg     <= 1'b0;
            end
            EM_PEND_LAST:
            begin
                item_out_reg <= pend_reg;
                status_reg   <= ST_FLUSHED;
                last_reg     <= 1'b1;
            end
            EM_EMPTY:
            begin
                item_out_reg <= '0;
                status_reg   <= ST_EMPTY;
                last_reg     <= 1'b1;
            end
            default:
            begin
                item_out_reg <= item_out_reg;
                status_reg   <= status_reg;
                last_reg     <= last_reg;
            end
        endcase
    end

    // status back to the controller
    assign stat.reject     = (items_used_reg >= USED_W'(ITEM_CAPACITY)) || !depth_ok;
    assign stat.cur_nz     = (cur != '0);
    assign stat.count_full = (count_reg >= ITEM_W'(ITEM_CAPACITY));
    assign stat.d_zero     = (d_reg == '0);
    assign stat.d_top      = (d_reg == AW'(DEPTH_LEVELS - 1));
    assign stat.pend_v     = pend_v_reg;

    assign strobe      = strobe_reg;
    assign item_number = item_out_reg;
    assign status      = status_reg;
    assign last        = last_reg;

endmodule

>>> rtl/dbot_ctrl.sv
// ----------------------------------------------------------------------------
// dbot_ctrl: sequencer of the ordering table
// Runs the head clearing sweep, inserts and the far-to-near flush walk.
// ----------------------------------------------------------------------------
module dbot_ctrl
    import dbot_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] opcode,
    input  dbot_stat_t stat,
    output dbot_cmd_t  cmd,
    output logic       busy
);

    typedef enum logic [6:0] {
        S_CLEAR    = 7'b0000001,
        S_IDLE     = 7'b0000010,
        S_INS      = 7'b0000100,
        S_HEAD     = 7'b0001000,
        S_CHK_HEAD = 7'b0010000,
        S_CHK_LINK = 7'b0100000,
        S_END      = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    // next state and commands
    always_comb
    begin
        state_next        = state_reg;
        cmd.head_sel      = HA_DEPTH_IN;
        cmd.head_we       = 1'b0;
        cmd.head_wd_item  = 1'b0;
        cmd.link_we       = 1'b0;
        cmd.cur_from_link = (state_reg == S_CHK_LINK);
        cmd.ins_load      = 1'b0;
        cmd.alloc_reset   = 1'b0;
        cmd.scan_init     = 1'b0;
        cmd.scan_dec      = 1'b0;
        cmd.sweep_inc     = 1'b0;
        cmd.push          = 1'b0;
        cmd.emit          = EM_NONE;

        case (state_reg)
            // zero every bucket head after reset
            S_CLEAR:
            begin
                cmd.head_sel  = HA_SCAN;
                cmd.head_we   = 1'b1;
                cmd.sweep_inc = 1'b1;
                if (stat.d_top)
                    state_next = S_IDLE;
            end

            // head read at the incoming depth runs every idle cycle
            S_IDLE:
            begin
                if (start)
                begin
                    case (opcode)
                        OP_INSERT:
                        begin
                            if (stat.reject)
                                cmd.emit = EM_REJECT;
                            else
                            begin
                                cmd.ins_load = 1'b1;
                                state_next   = S_INS;
                            end
                        end
                        OP_FLUSH:
                        begin
                            cmd.scan_init = 1'b1;
                            state_next    = S_HEAD;
                        end
                        OP_RESET:
                            cmd.alloc_reset = 1'b1;
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end

            // push the new item onto its bucket
            S_INS:
            begin
                cmd.head_sel     = HA_DEPTH_REG;
                cmd.head_we      = 1'b1;
                cmd.head_wd_item = 1'b1;
                cmd.link_we      = 1'b1;
                cmd.emit         = EM_INSERT;
                state_next       = S_IDLE;
            end

            // fetch and clear one bucket head
            S_HEAD:
            begin
                cmd.head_sel = HA_SCAN;
                cmd.head_we  = 1'b1;
                state_next   = S_CHK_HEAD;
            end

            // follow the list; held item goes out once its successor is known
            S_CHK_HEAD, S_CHK_LINK:
            begin
                cmd.head_sel = HA_SCAN;
                if (stat.cur_nz && !stat.count_full)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_CHK_LINK;
                    if (stat.pend_v)
                        cmd.emit = EM_PEND_MID;
                end
                else if (stat.d_zero)
                    state_next = S_END;
                else
                begin
                    cmd.scan_dec = 1'b1;
                    state_next   = S_HEAD;
                end
            end

            // closing word of the flush
            S_END:
            begin
                cmd.emit   = stat.pend_v ? EM_PEND_LAST : EM_EMPTY;
                state_next = S_IDLE;
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    // a flush word never leaves while the scan pointer is being stepped
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_dec |-> !cmd.push && cmd.emit == EM_NONE)
        else $error("scan step collided with an item push");

    // the sweep only leaves for idle
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR && state_next != S_CLEAR |-> stat.d_top)
        else $error("clearing sweep ended early");

    // an insert update always follows an accepted good insert
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins_load |=> state_reg == S_INS)
        else $error("insert load without write-back");

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the depth bucket ordering table
// Directed stimulus table followed by random insert/flush frames. Every
// accepted word runs through a local bucket-list predictor; each strobed
// result is checked field by field against the oldest expected word.
// ----------------------------------------------------------------------------
module tb;
    import dbot_pkg::*;

    localparam int         LEVELS     = 512;
    localparam int         CAPACITY   = 63;
    localparam int         NUM_WORDS  = 130;
    localparam int         IDLE_LIMIT = 8000;
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    // one result word
    typedef struct packed {
        logic [ITEM_W-1:0] item;
        logic [1:0]        st;
        logic              fin;
    } result_word_t;

    // one row of the directed table; typed rows carry their own expectation
    typedef struct {
        logic [1:0]         op;
        logic [DEPTH_W-1:0] dep;
        bit                 typed;
        logic [ITEM_W-1:0]  item;
        logic [1:0]         st;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         opcode;
    logic [DEPTH_W-1:0] depth;
    logic               strobe;
    logic [ITEM_W-1:0]  item_number;
    logic [1:0]         status;
    logic               last;

    // predictor state
    logic [ITEM_W-1:0]  head_mem [LEVELS];
    logic [ITEM_W-1:0]  link_mem [64];
    logic [USED_W-1:0]  used_cnt;
    logic [DEPTH_W-1:0] deepest;

    result_word_t pending_results[$];
    int           mismatches  = 0;
    int           idle_cycles = 0;
    int           words_sent  = 0;
    int           burst_left  = 0;

    stim_row_t directed [18] = '{
        '{OP_FLUSH,  9'd0,     1'b1, 6'd0, ST_EMPTY},
        '{OP_UNUSED, 9'h1ff,   1'b0, 6'd0, ST_EMPTY},
        '{OP_INSERT, 9'd0,     1'b1, 6'd1, ST_INSERTED},
        '{OP_INSERT, 9'd511,   1'b1, 6'd2, ST_INSERTED},
        '{OP_INSERT, 9'd0,     1'b0, 6'd0, ST_INSERTED},
        '{OP_INSERT, 9'h155,   1'b0, 6'd0, ST_INSERTED},
        '{OP_INSERT, 9'h0aa,   1'b0, 6'd0, ST_INSERTED},
        '{OP_FLUSH,  9'h1ff,   1'b0, 6'd0, ST_FLUSHED},
        '{OP_FLUSH,  9'd0,     1'b1, 6'd0, ST_EMPTY},
        '{OP_RESET,  9'd7,     1'b0, 6'd0, ST_EMPTY},
        '{OP_INSERT, 9'd5,     1'b1, 6'd1, ST_INSERTED},
        '{OP_INSERT, 9'd5,     1'b0, 6'd0, ST_INSERTED},
        // re-numbering into a stale bucket closes a loop: 1 -> 2 -> 1
        '{OP_RESET,  9'd0,     1'b0, 6'd0, ST_EMPTY},
        '{OP_INSERT, 9'd5,     1'b1, 6'd1, ST_INSERTED},
        '{OP_INSERT, 9'd5,     1'b0, 6'd0, ST_INSERTED},
        '{OP_FLUSH,  9'd0,     1'b0, 6'd0, ST_FLUSHED},
        '{OP_FLUSH,  9'd0,     1'b1, 6'd0, ST_EMPTY},
        '{OP_RESET,  9'd0,     1'b0, 6'd0, ST_EMPTY}
    };

    depth_bucket_ordering_table #(
        .DEPTH_LEVELS  (LEVELS),
        .ITEM_CAPACITY (CAPACITY)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .depth       (depth),
        .strobe      (strobe),
        .item_number (item_number),
        .status      (status),
        .last        (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 0;
    end

    // apply one accepted word to the predictor; queue its results if asked
    task automatic predict_table_op(input logic [1:0] op, input logic [DEPTH_W-1:0] dep,
                                    input bit record);
        logic [ITEM_W-1:0]  cur;
        logic [DEPTH_W-1:0] d;
        int                 emitted;
        bit                 have_prev;
        result_word_t       prev;
        begin
            emitted   = 0;
            have_prev = 1'b0;
            prev      = '0;
            case (op)
                OP_INSERT:
                begin
                    if (used_cnt >= CAPACITY || int'(dep) >= LEVELS)
                    begin
                        if (record)
                            pending_results.push_back('{'0, ST_REJECTED, 1'b1});
                    end
                    else
                    begin
                        cur      = ITEM_W'(used_cnt + 1);
                        used_cnt = used_cnt + USED_W'(1);
                        if (dep > deepest)
                            deepest = dep;
                        link_mem[cur] = head_mem[dep];
                        head_mem[dep] = cur;
                        if (record)
                            pending_results.push_back('{cur, ST_INSERTED, 1'b1});
                    end
                end
                OP_FLUSH:
                begin
                    d = deepest;
                    forever
                    begin
                        cur         = head_mem[d];
                        head_mem[d] = '0;
                        // emission stops at capacity, head clearing does not
                        while (cur != 0 && emitted < CAPACITY)
                        begin
                            if (have_prev && record)
                                pending_results.push_back(prev);
                            prev      = '{cur, ST_FLUSHED, 1'b0};
                            have_prev = 1'b1;
                            emitted++;
                            cur = link_mem[cur];
                        end
                        if (d == 0)
                            break;
                        d = d - DEPTH_W'(1);
                    end
                    if (record)
                    begin
                        if (have_prev)
                        begin
                            prev.fin = 1'b1;
                            pending_results.push_back(prev);
                        end
                        else
                            pending_results.push_back('{'0, ST_EMPTY, 1'b1});
                    end
                end
                OP_RESET:
                begin
                    used_cnt = '0;
                    deepest  = '0;
                end
                default: ;
            endcase
        end
    endtask

    // sender gap: mostly random, with occasional back-to-back bursts
    function automatic int draw_gap();
        int gap;
        begin
            if (burst_left > 0)
            begin
                burst_left--;
                gap = 0;
            end
            else
            begin
                gap = $urandom_range(0, 6);
                if ($urandom_range(0, 15) == 0)
                    burst_left = $urandom_range(8, 20);
            end
            return gap;
        end
    endfunction

    // mostly shallow depths keep flushes short; a few span the full range
    function automatic logic [DEPTH_W-1:0] draw_depth();
        int r;
        begin
            r = $urandom_range(0, 19);
            if (r == 0)
                return DEPTH_W'($urandom_range(0, LEVELS - 1));
            else if (r < 4)
                return DEPTH_W'($urandom_range(0, 63));
            else
                return DEPTH_W'($urandom_range(0, 15));
        end
    endfunction

    // present one word at the falling edge and hold it until accepted
    task automatic send_word(input logic [1:0] op, input logic [DEPTH_W-1:0] dep,
                             input bit typed, input result_word_t typed_word);
        int gap;
        begin
            gap = draw_gap();
            @(negedge clk);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            start  <= 1'b1;
            opcode <= op;
            depth  <= dep;
            do
                @(posedge clk);
            while (busy);
            predict_table_op(op, dep, !typed);
            if (typed)
                pending_results.push_back(typed_word);
            if (op != OP_UNUSED)
                words_sent++;
        end
    endtask

    task automatic send_plain(input logic [1:0] op, input logic [DEPTH_W-1:0] dep);
        begin
            send_word(op, dep, 1'b0, '0);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result item_number %0d status %0d last %0d",
                         $time, item_number, status, last);
                mismatches++;
            end
            else
            begin
                result_word_t want;
                want = pending_results.pop_front();
                if (item_number !== want.item)
                begin
                    $display("%0t: item_number expected %0d actual %0d",
                             $time, want.item, item_number);
                    mismatches++;
                end
                if (status !== want.st)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, want.st, status);
                    mismatches++;
                end
                if (last !== want.fin)
                begin
                    $display("%0t: last expected %0d actual %0d", $time, want.fin, last);
                    mismatches++;
                end
            end
        end
    end

    // watchdog: cycles with neither a word accepted nor a result strobed
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, idle_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int n;
        int r;
        rst_n  = 1'b0;
        start  = 1'b0;
        opcode = OP_INSERT;
        depth  = '0;
        for (int i = 0; i < LEVELS; i++)
            head_mem[i] = '0;
        for (int i = 0; i < 64; i++)
            link_mem[i] = '0;
        used_cnt = '0;
        deepest  = '0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (directed[i])
            send_word(directed[i].op, directed[i].dep, directed[i].typed,
                      '{directed[i].item, directed[i].st, 1'b1});

        // fill the pool past capacity, then drain it
        send_plain(OP_RESET, draw_depth());
        n = $urandom_range(64, 66);
        for (int i = 0; i < n; i++)
            send_plain(OP_INSERT, draw_depth());
        send_plain(OP_FLUSH, draw_depth());

        // random frames: optional allocator reset, inserts with noise, flush
        while (words_sent < NUM_WORDS)
        begin
            if ($urandom_range(0, 3) == 0)
                send_plain(OP_RESET, draw_depth());
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
            for (int i = 0; i < n; i++)
            begin
                r = $urandom_range(0, 15);
                if (r == 0)
                    send_plain(OP_UNUSED, draw_depth());
                else if (r == 1)
                    send_plain(OP_RESET, draw_depth());
                else if (r == 2)
                    send_plain(OP_FLUSH, draw_depth());
                else
                    send_plain(OP_INSERT, draw_depth());
            end
            send_plain(OP_FLUSH, draw_depth());
        end

        @(negedge clk);
        start <= 1'b0;

        // drain, then let the block settle before the verdict
        while (pending_results.size() != 0)
            @(posedge clk);
        while (busy)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
